// ----- src/csg_pkg.sv -----
// Package: shared types and constants for the CAN command frame segmenter.
`default_nettype none
package csg_pkg;

  // Payload bytes carried by one frame (data byte 0 is the function code)
  localparam int unsigned PAYLOAD_PER_FRAME = 7;
  localparam int unsigned BUF_DEPTH         = 7;
  localparam int unsigned CNT_W             = $clog2(BUF_DEPTH + 1);

  // One input beat as held in the input register
  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       last_byte;
  } in_beat_t;

  // One result beat as held in the output register
  typedef struct packed {
    logic [15:0] frame_ext_id;
    logic [3:0]  frame_dlc;
    logic [63:0] frame_data;
    logic        final_frame;
  } frame_t;

endpackage
`default_nettype wire

// ----- src/csg_in_stage.sv -----
// Input register stage: holds one command byte until the frame builder takes it.
`default_nettype none
module csg_in_stage
  import csg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic [7:0] in_cmd_byte,
  input  wire logic     in_last_byte,
  input  wire logic     take,
  output logic          beat_valid,
  output in_beat_t      beat
);

  logic     valid_r;
  logic     valid_nxt;
  in_beat_t beat_r;
  logic     load;

  // Register is free when empty or when its beat moves on this cycle
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      beat_r.cmd_byte  <= in_cmd_byte;
      beat_r.last_byte <= in_last_byte;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule
`default_nettype wire

// ----- src/csg_frame_builder.sv -----
// Frame builder: command parsing, payload buffer and the output frame register.
`default_nettype none
module csg_frame_builder
  import csg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic beat_valid,
  input  wire in_beat_t beat,
  output logic      take,
  output logic      out_valid,
  input  wire logic out_stall,
  output frame_t    frame
);

  typedef enum logic [1:0] {
    PH_ADDR = 2'd0,
    PH_FUNC = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [7:0]       buf_r [BUF_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       pkt_r, pkt_nxt;
  logic             out_valid_r, out_valid_nxt;
  frame_t           frame_r, frame_nxt;
  logic             buf_we;
  logic [CNT_W-1:0] cnt_inc;
  logic             emit;
  logic [63:0]      data_w;

  // Output register accepts a new frame when empty or drained this cycle
  assign take    = !out_valid_r || !out_stall;
  assign cnt_inc = cnt_r + CNT_W'(1);

  // Assemble data bytes: function code, buffered payload, current byte, zeros
  always_comb begin
    data_w[7:0] = func_r;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      if (CNT_W'(i) == cnt_r) begin
        data_w[8*(i+1) +: 8] = beat.cmd_byte;
      end else if (CNT_W'(i) < cnt_r) begin
        data_w[8*(i+1) +: 8] = buf_r[i];
      end else begin
        data_w[8*(i+1) +: 8] = 8'h00;
      end
    end
  end

  // Per-byte command parsing
  always_comb begin
    phase_nxt     = phase_r;
    addr_nxt      = addr_r;
    func_nxt      = func_r;
    cnt_nxt       = cnt_r;
    pkt_nxt       = pkt_r;
    buf_we        = 1'b0;
    emit          = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    frame_nxt     = frame_r;
    if (beat_valid && take) begin
      unique case (phase_r)
        PH_FUNC: begin
          func_nxt = beat.cmd_byte;
          if (beat.last_byte) begin
            phase_nxt = PH_ADDR;
            cnt_nxt   = '0;
            pkt_nxt   = 8'h00;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          buf_we  = 1'b1;
          cnt_nxt = cnt_inc;
          emit    = beat.last_byte || (cnt_inc >= CNT_W'(PAYLOAD_PER_FRAME));
          if (emit) begin
            frame_nxt.frame_ext_id = {addr_r, pkt_r};
            frame_nxt.frame_dlc    = 4'(cnt_inc) + 4'd1;
            frame_nxt.frame_data   = data_w;
            frame_nxt.final_frame  = beat.last_byte;
            out_valid_nxt          = 1'b1;
            cnt_nxt                = '0;
            if (beat.last_byte) begin
              phase_nxt = PH_ADDR;
              pkt_nxt   = 8'h00;
            end else begin
              pkt_nxt = pkt_r + 8'd1;
            end
          end
        end
        default: begin
          // Address byte; an unused phase code is treated the same way
          addr_nxt  = beat.cmd_byte;
          cnt_nxt   = '0;
          pkt_nxt   = 8'h00;
          phase_nxt = beat.last_byte ? PH_ADDR : PH_FUNC;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ADDR;
      cnt_r       <= '0;
      pkt_r       <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      pkt_r       <= pkt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: written before they are read, no reset
  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    func_r  <= func_nxt;
    frame_r <= frame_nxt;
    if (buf_we) begin
      buf_r[cnt_r[CNT_W-1:0]] <= beat.cmd_byte;
    end
  end

  assign out_valid = out_valid_r;
  assign frame     = frame_r;

endmodule
`default_nettype wire

// ----- src/can_command_frame_segmenter_unit.sv -----
// Top level: CAN command frame segmenter, command bytes in, CAN data frames out.
//
// Input channel (in_*): one command byte per beat, in_last_byte marks the
// final byte. Byte 0 is the device address, byte 1 the function code, the
// rest is payload. Output channel (out_*): one extended data frame per beat,
// ID = {address, packet number}, data byte 0 = function code, then up to
// seven payload bytes, unused bytes zero, DLC = payload count + 1.
// A frame leaves when seven payload bytes are gathered or on a final payload
// byte; a command with no payload gives no frame. An accepted byte waits in
// the input register; its frame, if any, is loaded into the output register
// when the frame builder takes that byte. Throughput: one byte per cycle
// while out_stall holds no frame; the input register and the output frame
// register form a two-stage pipe, so a byte is taken while a frame waits.
// When out_stall holds a frame, the input register keeps its byte and
// in_stall rises once it is full; beats resume with no loss.
// Reset (rst_n low, synchronous): both registers empty, parser waits for an
// address byte, packet number is zero.
`default_nettype none
module can_command_frame_segmenter_unit
  import csg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_cmd_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_frame_ext_id,
  output logic [3:0]       out_frame_dlc,
  output logic [63:0]      out_frame_data,
  output logic             out_final_frame
);

  logic     take;
  logic     beat_valid;
  in_beat_t beat;
  frame_t   frame;

  // Input register
  csg_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd_byte (in_cmd_byte),
    .in_last_byte(in_last_byte),
    .take        (take),
    .beat_valid  (beat_valid),
    .beat        (beat)
  );

  // Parser and frame register
  csg_frame_builder u_frame_builder (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_valid(beat_valid),
    .beat      (beat),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .frame     (frame)
  );

  assign out_frame_ext_id = frame.frame_ext_id;
  assign out_frame_dlc    = frame.frame_dlc;
  assign out_frame_data   = frame.frame_data;
  assign out_final_frame  = frame.final_frame;

  // Input side only backs up behind a held frame
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output frame");

  // Frame length stays within 2..8
  a_dlc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_dlc >= 4'd2 && out_frame_dlc <= 4'd8))
    else $error("frame DLC out of range");

  // A short frame can only close a command
  a_short_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_dlc != 4'd8) |-> out_final_frame)
    else $error("partial frame not marked final");

endmodule
`default_nettype wire

// ----- tb/can_command_frame_segmenter_unit_tb.sv -----
// Testbench: CAN command frame segmenter, random byte stream checked against a frame predictor.
`timescale 1ns / 1ps
module can_command_frame_segmenter_unit_tb;
  import csg_pkg::*;

  // Predicts frames from accepted command bytes and checks the frames that leave
  class frame_scoreboard;
    typedef enum logic [1:0] {WANT_ADDR, WANT_FUNC, WANT_PAYLOAD} parse_phase_e;

    parse_phase_e phase;
    logic [7:0]   dev_addr;
    logic [7:0]   func_code;
    logic [7:0]   payload_bytes [BUF_DEPTH];
    logic [2:0]   pending;
    logic [7:0]   pkt_num;
    frame_t       expected_frames[$];
    int           errors;

    function new();
      phase     = WANT_ADDR;
      dev_addr  = '0;
      func_code = '0;
      foreach (payload_bytes[i]) payload_bytes[i] = '0;
      pending   = '0;
      pkt_num   = '0;
      errors    = 0;
    endfunction

    // One accepted input beat: advance the parser, queue a frame when one is due
    function void note_byte(logic [7:0] b, logic last);
      frame_t f;
      case (phase)
        WANT_FUNC: begin
          func_code = b;
          if (last) begin
            phase   = WANT_ADDR;
            pending = '0;
            pkt_num = '0;
          end else begin
            phase = WANT_PAYLOAD;
          end
        end
        WANT_PAYLOAD: begin
          payload_bytes[pending] = b;
          pending = pending + 3'd1;
          if (pending == PAYLOAD_PER_FRAME || last) begin
            f.frame_ext_id = {dev_addr, pkt_num};
            f.frame_dlc    = 4'(pending) + 4'd1;
            f.frame_data   = 64'(func_code);
            for (int i = 0; i < pending; i++) f.frame_data[8*(i+1) +: 8] = payload_bytes[i];
            f.final_frame  = last;
            expected_frames.push_back(f);
            pending = '0;
            if (last) begin
              phase   = WANT_ADDR;
              pkt_num = '0;
            end else begin
              pkt_num = pkt_num + 8'd1;
            end
          end
        end
        default: begin
          // address byte; a lone address marked last is dropped
          dev_addr = b;
          pending  = '0;
          pkt_num  = '0;
          phase    = last ? WANT_ADDR : WANT_FUNC;
        end
      endcase
    endfunction

    function void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        if (errors <= 10)
          $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, act_v);
      end
    endfunction

    // One accepted output beat: compare with the oldest expected frame
    function void check_frame(frame_t got);
      frame_t exp_f;
      if (expected_frames.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected frame id 0x%0h data 0x%0h", $time, got.frame_ext_id,
                   got.frame_data);
        return;
      end
      exp_f = expected_frames.pop_front();
      report("frame_ext_id", 64'(exp_f.frame_ext_id), 64'(got.frame_ext_id));
      report("frame_dlc", 64'(exp_f.frame_dlc), 64'(got.frame_dlc));
      report("frame_data", exp_f.frame_data, got.frame_data);
      report("final_frame", 64'(exp_f.final_frame), 64'(got.final_frame));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_cmd_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_frame_ext_id;
  logic [3:0]  out_frame_dlc;
  logic [63:0] out_frame_data;
  logic        out_final_frame;

  frame_scoreboard frames_sb = new();
  bit              quiet;
  int              beats_sent;

  can_command_frame_segmenter_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd_byte      (in_cmd_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_ext_id (out_frame_ext_id),
    .out_frame_dlc    (out_frame_dlc),
    .out_frame_data   (out_frame_data),
    .out_final_frame  (out_final_frame)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver stalls at random unless in a quiet stretch
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 37);
  end

  // Beat monitors
  always @(posedge clk) begin
    frame_t got;
    if (rst_n && in_valid && !in_stall) frames_sb.note_byte(in_cmd_byte, in_last_byte);
    if (rst_n && out_valid && !out_stall) begin
      got.frame_ext_id = out_frame_ext_id;
      got.frame_dlc    = out_frame_dlc;
      got.frame_data   = out_frame_data;
      got.final_frame  = out_final_frame;
      frames_sb.check_frame(got);
    end
  end

  // Drive one byte, with random gaps ahead of it, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!quiet && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd_byte  <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Random address, function code and payload; negative length sends a lone address
  task automatic send_command(input int payload_len);
    if (payload_len < 0) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(8'($urandom_range(0, 255)), payload_len == 0);
      for (int i = 0; i < payload_len; i++)
        send_byte(8'($urandom_range(0, 255)), i == payload_len - 1);
    end
  endtask

  // Stop sending and wait for every expected frame
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_sb.expected_frames.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sel;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_cmd_byte  <= '0;
    in_last_byte <= 1'b0;
    quiet        = 1'b0;
    beats_sent   = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: lone address, command without payload
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // exactly one full frame, closed by the final byte
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h55, 1'b1);
    // full frame then a one-byte tail
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    for (int i = 0; i < 7; i++) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // Hold off until the pipe is empty
    wait_drained();

    // Random commands, mostly well formed
    while (beats_sent < 290) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) send_command(-1);
      else if (sel < 16) send_command(0);
      else if (sel < 80) send_command($urandom_range(1, 14));
      else send_command($urandom_range(15, 30));
    end

    // Longer command without idling: several full frames back to back
    quiet = 1'b1;
    send_command(6 * 7 + 3);
    quiet = 1'b0;

    // A few more after the quiet stretch
    repeat (6) send_command($urandom_range(0, 10));

    wait_drained();
    repeat (8) @(posedge clk);
    if (frames_sb.errors == 0 && frames_sb.expected_frames.size() == 0) begin
      $display("can_command_frame_segmenter_unit test passed");
    end else begin
      $display("can_command_frame_segmenter_unit test failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("can_command_frame_segmenter_unit test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/csg_pkg.sv
src/csg_in_stage.sv
src/csg_frame_builder.sv
src/can_command_frame_segmenter_unit.sv
tb/can_command_frame_segmenter_unit_tb.sv
